/* design/lrc_pkg.sv */
// Shared constants for the line rectangle clipper.
`default_nettype none
package lrc_pkg;
  localparam int COORD_WIDTH   = 16;
  localparam int NUM_ITER      = 4;
  localparam int DIV_STEP_BITS = 4;
  localparam int CFG_IDX_W     = 8;

  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_TOP    = 4'b1000;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 8'd3;

  localparam int X_MIN_RST = 150;
  localparam int X_MAX_RST = 540;
  localparam int Y_MIN_RST = 174;
  localparam int Y_MAX_RST = 449;
endpackage
`default_nettype wire

/* design/line_rect_clipper.sv */
// Throughput: one segment per cycle while m_axis_tready does not hold the pipe;
// each clip pass is a 7-stage pipe set by the divider.
// The whole pipe holds while a result waits on m_axis_tready.
// Reset: asynchronous active low; clears valid bits and loads the default window.
// Configuration registers are always ready; unknown indexes are ignored.
`default_nettype none
module line_rect_clipper import lrc_pkg::*; #(
  parameter int COORD_W = COORD_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [COORD_W-1:0]     cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic [((4*COORD_W+8)/8)*8-1:0] m_axis_tdata
);
  localparam int W   = COORD_W;
  localparam int ODW = ((4*W+8)/8)*8;

  typedef struct packed {
    logic signed [W-1:0] x1, y1, x2, y2;
  } seg_t;

  typedef struct packed {
    logic signed [W-1:0] xmin, xmax, ymin, ymax;
  } win_t;

  function automatic logic [3:0] oc(logic signed [W-1:0] x, logic signed [W-1:0] y, win_t w);
    logic [3:0] c;
    c = '0;
    if (x < w.xmin) c |= OC_LEFT;
    else if (x > w.xmax) c |= OC_RIGHT;
    if (y < w.ymin) c |= OC_BOTTOM;
    else if (y > w.ymax) c |= OC_TOP;
    return c;
  endfunction

  win_t win_q;
  logic en;
  logic out_vis_q;
  seg_t out_seg_q;
  logic out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.xmin <= W'(X_MIN_RST);
      win_q.xmax <= W'(X_MAX_RST);
      win_q.ymin <= W'(Y_MIN_RST);
      win_q.ymax <= W'(Y_MAX_RST);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_X_MIN: win_q.xmin <= cfg_data_i;
        REG_X_MAX: win_q.xmax <= cfg_data_i;
        REG_Y_MIN: win_q.ymin <= cfg_data_i;
        REG_Y_MAX: win_q.ymax <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [NUM_ITER:0]  v;
  logic [4*W-1:0]     sg [NUM_ITER+1];
  seg_t               sin;

  assign sin.x1 = s_axis_tdata[W-1:0];
  assign sin.y1 = s_axis_tdata[2*W-1:W];
  assign sin.x2 = s_axis_tdata[3*W-1:2*W];
  assign sin.y2 = s_axis_tdata[4*W-1:3*W];
  assign v[0]  = s_axis_tvalid;
  assign sg[0] = sin;

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_pass
    lrc_iter #(.W(W)) u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .win_i   (win_q),
      .valid_i (v[i]),
      .seg_i   (sg[i]),
      .valid_o (v[i+1]),
      .seg_o   (sg[i+1])
    );
  end

  seg_t fin;
  logic ok;
  assign fin = seg_t'(sg[NUM_ITER]);
  assign ok  = (oc(fin.x1, fin.y1, win_q) == 4'b0) && (oc(fin.x2, fin.y2, win_q) == 4'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[NUM_ITER];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_vis_q <= ok;
      out_seg_q <= ok ? fin : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'({out_seg_q.y2, out_seg_q.x2, out_seg_q.y1, out_seg_q.x1,
                               out_vis_q});

  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4*W:1] == '0)
    else $error("rejected segment with nonzero endpoints");

  a_vis_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      oc(out_seg_q.x1, out_seg_q.y1, win_q) == 4'b0 &&
      oc(out_seg_q.x2, out_seg_q.y2, win_q) == 4'b0)
    else $error("visible segment endpoint outside window");
endmodule
`default_nettype wire

/* design/lrc_iter.sv */
// One pipelined clip pass: edge select, multiply, radix-16 divide, endpoint update.
`default_nettype none
module lrc_iter import lrc_pkg::*; #(
  parameter int W = COORD_WIDTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic [4*W-1:0] win_i,
  input  wire logic           valid_i,
  input  wire logic [4*W-1:0] seg_i,
  output logic                valid_o,
  output logic [4*W-1:0]      seg_o
);
  localparam int ND  = (W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int NST = ND + 3;

  typedef struct packed {
    logic signed [W-1:0] x1, y1, x2, y2;
  } seg_t;

  typedef struct packed {
    logic signed [W-1:0] xmin, xmax, ymin, ymax;
  } win_t;

  typedef struct packed {
    seg_t                seg;
    logic                clip, mv1, xedge, neg;
    logic signed [W-1:0] e, a;
    logic [W-1:0]        ma, mb, md, rem, low, q;
  } ctx_t;

  function automatic logic [3:0] oc(logic signed [W-1:0] x, logic signed [W-1:0] y, win_t w);
    logic [3:0] c;
    c = '0;
    if (x < w.xmin) c |= OC_LEFT;
    else if (x > w.xmax) c |= OC_RIGHT;
    if (y < w.ymin) c |= OC_BOTTOM;
    else if (y > w.ymax) c |= OC_TOP;
    return c;
  endfunction

  function automatic logic [W-1:0] mag(logic signed [W:0] v);
    logic signed [W:0] m;
    m = v[W] ? -v : v;
    return m[W-1:0];
  endfunction

  win_t win;
  seg_t sin;
  assign win = win_t'(win_i);
  assign sin = seg_t'(seg_i);

  ctx_t             st_q [NST];
  ctx_t             st_d [NST];
  logic [NST-1:0]   v_q;

  // edge select
  always_comb begin
    logic [3:0] c1, c2, c;
    logic signed [W:0] bd, nd, dd;
    st_d[0] = '0;
    st_d[0].seg = sin;
    c1 = oc(sin.x1, sin.y1, win);
    c2 = oc(sin.x2, sin.y2, win);
    st_d[0].clip = ((c1 & c2) == 4'b0) && ((c1 | c2) != 4'b0);
    st_d[0].mv1 = (c1 != 4'b0);
    c = (c1 != 4'b0) ? c1 : c2;
    if ((c & OC_LEFT) != 4'b0) begin
      st_d[0].xedge = 1'b1;
      st_d[0].e = win.xmin;
    end else if ((c & OC_RIGHT) != 4'b0) begin
      st_d[0].xedge = 1'b1;
      st_d[0].e = win.xmax;
    end else if ((c & OC_BOTTOM) != 4'b0) begin
      st_d[0].xedge = 1'b0;
      st_d[0].e = win.ymin;
    end else begin
      st_d[0].xedge = 1'b0;
      st_d[0].e = win.ymax;
    end
    if (st_d[0].xedge) begin
      st_d[0].a = sin.y1;
      bd = (W+1)'(sin.y2) - (W+1)'(sin.y1);
      nd = (W+1)'(st_d[0].e) - (W+1)'(sin.x1);
      dd = (W+1)'(sin.x2) - (W+1)'(sin.x1);
    end else begin
      st_d[0].a = sin.x1;
      bd = (W+1)'(sin.x2) - (W+1)'(sin.x1);
      nd = (W+1)'(st_d[0].e) - (W+1)'(sin.y1);
      dd = (W+1)'(sin.y2) - (W+1)'(sin.y1);
    end
    st_d[0].neg = bd[W] ^ nd[W] ^ dd[W];
    st_d[0].ma = mag(bd);
    st_d[0].mb = mag(nd);
    st_d[0].md = mag(dd);
  end

  // multiply
  always_comb begin
    logic [2*W-1:0] p;
    st_d[1] = st_q[0];
    p = st_q[0].ma * st_q[0].mb;
    st_d[1].rem = p[2*W-1:W];
    st_d[1].low = p[W-1:0];
    st_d[1].q = '0;
  end

  // divide, DIV_STEP_BITS quotient bits per stage
  for (genvar k = 0; k < ND; k++) begin : g_div
    always_comb begin
      logic [W:0] r;
      st_d[k+2] = st_q[k+1];
      for (int j = 0; j < DIV_STEP_BITS; j++) begin
        if (k * DIV_STEP_BITS + j < W) begin
          r = {st_d[k+2].rem, st_d[k+2].low[W-1]};
          st_d[k+2].low = st_d[k+2].low << 1;
          if (r >= {1'b0, st_d[k+2].md}) begin
            r = r - {1'b0, st_d[k+2].md};
            st_d[k+2].q = {st_d[k+2].q[W-2:0], 1'b1};
          end else begin
            st_d[k+2].q = {st_d[k+2].q[W-2:0], 1'b0};
          end
          st_d[k+2].rem = r[W-1:0];
        end
      end
    end
  end

  // endpoint update
  always_comb begin
    logic signed [W:0] qs, res;
    ctx_t s;
    s = st_q[NST-2];
    st_d[NST-1] = s;
    qs = s.neg ? -$signed({1'b0, s.q}) : $signed({1'b0, s.q});
    res = (W+1)'(s.a) + qs;
    if (s.clip) begin
      if (s.mv1) begin
        st_d[NST-1].seg.x1 = s.xedge ? s.e : res[W-1:0];
        st_d[NST-1].seg.y1 = s.xedge ? res[W-1:0] : s.e;
      end else begin
        st_d[NST-1].seg.x2 = s.xedge ? s.e : res[W-1:0];
        st_d[NST-1].seg.y2 = s.xedge ? res[W-1:0] : s.e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NST; i++) st_q[i] <= st_d[i];
    end
  end

  assign valid_o = v_q[NST-1];
  assign seg_o   = st_q[NST-1].seg;
endmodule
`default_nettype wire
